FILE: design/rbc_pkg.sv
// Package for the red blob centroid detector: field widths, reset values,
// configuration register indexes and the controller command struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbc_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int COUNT_W    = 21;
  localparam int SUM_W      = 30;
  localparam int RUN_W      = 6;
  localparam int QUO_W      = COORD_W + 1;
  localparam int STEP_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [RUN_W-1:0]      run_t;
  typedef logic [QUO_W-1:0]      quo_t;
  typedef logic [STEP_W-1:0]     step_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam run_t   RUN_MAX   = '1;
  localparam coord_t COORD_MAX = '1;

  // Reset values of the configuration registers.
  localparam pix_t   REDNESS_RST = 8'd90;
  localparam count_t AREA_RST    = 21'd550;
  localparam run_t   CONF_RST    = 6'd20;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_REDNESS = 2'd0;
  localparam cfg_idx_t CFG_AREA    = 2'd1;
  localparam cfg_idx_t CFG_CONF    = 2'd2;

  // The divider produces one quotient bit per step, most significant first;
  // the top bit only flags a quotient that needs clamping.
  localparam step_t DIV_FIRST_STEP = step_t'(COORD_W);

  typedef struct packed {
    logic  accumulate;
    logic  frame_close;
    logic  load_div;
    logic  load_clear;
    logic  div_step;
    step_t step;
  } rbc_cmd_t;

endpackage

`default_nettype wire

FILE: design/rbc_pix_if.sv
// Pixel request channel: valid, ready and one pixel with its position.
// Depends on rbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rbc_pix_if;
  import rbc_pkg::*;

  logic   valid;
  logic   ready;
  pix_t   blue;
  pix_t   green;
  pix_t   red;
  coord_t column;
  coord_t row_index;
  logic   frame_end;

  modport source (output valid, blue, green, red, column, row_index, frame_end,
                  input ready);
  modport sink   (input valid, blue, green, red, column, row_index, frame_end,
                  output ready);
endinterface

`default_nettype wire

FILE: design/rbc_res_if.sv
// Result request channel: valid, ready and one detection verdict.
// Depends on rbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rbc_res_if;
  import rbc_pkg::*;

  logic   valid;
  logic   ready;
  logic   stop_detected;
  coord_t centroid_x;
  coord_t centroid_y;

  modport source (output valid, stop_detected, centroid_x, centroid_y,
                  input ready);
  modport sink   (input valid, stop_detected, centroid_x, centroid_y,
                  output ready);
endinterface

`default_nettype wire

FILE: design/rbc_datapath.sv
// Datapath: pixel classification, per-frame accumulators and the
// bit-serial centroid divider with its result registers. Depends on rbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbc_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr_en,
  input  rbc_pkg::cfg_idx_t   cfg_index,
  input  rbc_pkg::cfg_data_t  cfg_data,
  input  rbc_pkg::rbc_cmd_t   cmd,
  input  rbc_pkg::pix_t       blue,
  input  rbc_pkg::pix_t       green,
  input  rbc_pkg::pix_t       red,
  input  rbc_pkg::coord_t     column,
  input  rbc_pkg::coord_t     row_index,
  output logic                frame_red,
  output logic                stop_detected,
  output rbc_pkg::coord_t     centroid_x,
  output rbc_pkg::coord_t     centroid_y
);
  import rbc_pkg::*;

  // Wide enough for any position limit up to 4096.
  localparam int POS_W = COORD_W + 3;
  localparam int DSH_W = COUNT_W + COORD_W;

  pix_t   redness_r;
  count_t area_r;
  count_t count_r, count_nxt, count_fin;
  sum_t   colsum_r, colsum_nxt, colsum_fin;
  sum_t   rowsum_r, rowsum_nxt, rowsum_fin;
  count_t div_r, div_nxt;
  sum_t   rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  quo_t   q_x_r, q_x_nxt, q_y_r, q_y_nxt;
  logic   stop_r, stop_nxt;

  pix_t   diff_rg, excess;
  logic   in_frame, hit;
  logic [COUNT_W:0]   count_add;
  logic [SUM_W:0]     col_add, row_add;
  logic [DSH_W-1:0]   d_sh, rx_ext, ry_ext, rx_diff, ry_diff;

  // Configuration registers owned by the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      redness_r <= REDNESS_RST;
      area_r    <= AREA_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_REDNESS: redness_r <= cfg_data[PIX_W-1:0];
        CFG_AREA:    area_r    <= cfg_data[COUNT_W-1:0];
        default:     ;
      endcase
    end
  end

  // Saturating red excess and the qualification test.
  always_comb begin
    diff_rg  = (red > green) ? red - green : '0;
    excess   = (diff_rg > blue) ? diff_rg - blue : '0;
    in_frame = (POS_W'(column) < POS_W'(MAX_WIDTH)) &&
               (POS_W'(row_index) < POS_W'(MAX_HEIGHT));
    hit      = cmd.accumulate && in_frame && (excess >= redness_r);
  end

  // Accumulators saturate instead of wrapping; the frame-end pixel is
  // counted before the frame is judged.
  always_comb begin
    count_add  = {1'b0, count_r} + (COUNT_W + 1)'(hit);
    col_add    = {1'b0, colsum_r} + (SUM_W + 1)'(hit ? column : '0);
    row_add    = {1'b0, rowsum_r} + (SUM_W + 1)'(hit ? row_index : '0);
    count_fin  = count_add[COUNT_W] ? '1 : count_add[COUNT_W-1:0];
    colsum_fin = col_add[SUM_W] ? '1 : col_add[SUM_W-1:0];
    rowsum_fin = row_add[SUM_W] ? '1 : row_add[SUM_W-1:0];
    frame_red  = count_fin > area_r;
    if (cmd.frame_close) begin
      count_nxt  = '0;
      colsum_nxt = '0;
      rowsum_nxt = '0;
    end else begin
      count_nxt  = count_fin;
      colsum_nxt = colsum_fin;
      rowsum_nxt = rowsum_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      colsum_r <= '0;
      rowsum_r <= '0;
    end else begin
      count_r  <= count_nxt;
      colsum_r <= colsum_nxt;
      rowsum_r <= rowsum_nxt;
    end
  end

  // Restoring division of both sums by the count, one quotient bit of each
  // per step. The divisor is never zero for a detect result.
  always_comb begin
    d_sh      = DSH_W'(div_r) << cmd.step;
    rx_ext    = DSH_W'(rem_x_r);
    ry_ext    = DSH_W'(rem_y_r);
    rx_diff   = rx_ext - d_sh;
    ry_diff   = ry_ext - d_sh;
    div_nxt   = div_r;
    rem_x_nxt = rem_x_r;
    rem_y_nxt = rem_y_r;
    q_x_nxt   = q_x_r;
    q_y_nxt   = q_y_r;
    stop_nxt  = stop_r;
    if (cmd.load_div) begin
      div_nxt   = count_fin;
      rem_x_nxt = colsum_fin;
      rem_y_nxt = rowsum_fin;
      q_x_nxt   = '0;
      q_y_nxt   = '0;
      stop_nxt  = 1'b1;
    end else if (cmd.load_clear) begin
      q_x_nxt  = '0;
      q_y_nxt  = '0;
      stop_nxt = 1'b0;
    end else if (cmd.div_step) begin
      if (rx_ext >= d_sh) begin
        rem_x_nxt          = rx_diff[SUM_W-1:0];
        q_x_nxt[cmd.step]  = 1'b1;
      end
      if (ry_ext >= d_sh) begin
        rem_y_nxt          = ry_diff[SUM_W-1:0];
        q_y_nxt[cmd.step]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    div_r   <= div_nxt;
    rem_x_r <= rem_x_nxt;
    rem_y_r <= rem_y_nxt;
    q_x_r   <= q_x_nxt;
    q_y_r   <= q_y_nxt;
    stop_r  <= stop_nxt;
  end

  // A quotient of 1024 or more is clamped to the largest coordinate.
  assign stop_detected = stop_r;
  assign centroid_x    = q_x_r[COORD_W] ? COORD_MAX : q_x_r[COORD_W-1:0];
  assign centroid_y    = q_y_r[COORD_W] ? COORD_MAX : q_y_r[COORD_W-1:0];

endmodule

`default_nettype wire

FILE: design/rbc_ctrl.sv
// Controller: run counters, the frame verdict and the sequencing of the
// divider and the result register. Depends on rbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr_en,
  input  rbc_pkg::cfg_idx_t   cfg_index,
  input  rbc_pkg::cfg_data_t  cfg_data,
  input  wire                 in_valid,
  input  wire                 in_frame_end,
  input  wire                 frame_red,
  input  wire                 out_ready,
  output logic                in_ready,
  output logic                out_valid,
  output rbc_pkg::rbc_cmd_t   cmd
);
  import rbc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  step_t      step_r, step_nxt;
  run_t       det_r, det_nxt, clr_r, clr_nxt;
  run_t       limit_r;
  run_t       det_inc, clr_inc;
  logic       accept, close;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= CONF_RST;
    end else if (cfg_wr_en && cfg_index == CFG_CONF) begin
      limit_r <= cfg_data[RUN_W-1:0];
    end
  end

  // Ordinary pixels are always taken; a frame-end pixel waits until the
  // previous verdict has been handed over.
  assign in_ready  = !(in_frame_end && state_r != ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign close     = accept && in_frame_end;
  assign out_valid = (state_r == ST_OUT);
  assign det_inc   = (det_r == RUN_MAX) ? RUN_MAX : det_r + 1'b1;
  assign clr_inc   = (clr_r == RUN_MAX) ? RUN_MAX : clr_r + 1'b1;

  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    det_nxt         = det_r;
    clr_nxt         = clr_r;
    cmd             = '0;
    cmd.accumulate  = accept;
    cmd.frame_close = close;
    cmd.step        = step_r;
    case (state_r)
      ST_IDLE: begin
        if (close) begin
          if (frame_red) begin
            if (det_inc > limit_r) begin
              det_nxt      = '0;
              cmd.load_div = 1'b1;
              step_nxt     = DIV_FIRST_STEP;
              state_nxt    = ST_DIV;
            end else begin
              det_nxt = det_inc;
            end
          end else begin
            if (clr_inc > limit_r) begin
              clr_nxt        = '0;
              cmd.load_clear = 1'b1;
              state_nxt      = ST_OUT;
            end else begin
              clr_nxt = clr_inc;
            end
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      det_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      det_r   <= det_nxt;
      clr_r   <= clr_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/red_blob_centroid_detector_top.sv
// Throughput: one pixel request per cycle; only a frame-end pixel can be held off.
// A clear verdict is offered in the cycle after its frame-end pixel is taken, a detect
// verdict once the divider has been loaded and has run its eleven divider steps.
// A further frame-end pixel waits until the previous verdict has been taken.
// Reset (rst_n, synchronous, active low) restores the register defaults and
// clears the accumulators, the run counters and the controller.
`timescale 1ns / 1ps
`default_nettype none

module red_blob_centroid_detector_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire                 clk,
  input  wire                 rst_n,
  rbc_pix_if.sink             in_pix,
  rbc_res_if.source           out_res,
  input  wire                 cfg_wr_en,
  input  rbc_pkg::cfg_idx_t   cfg_index,
  input  rbc_pkg::cfg_data_t  cfg_data
);
  import rbc_pkg::*;

  // The controller and the datapath exchange only the command struct and
  // the frame verdict. Pixels flow into the datapath continuously, so the
  // division for one frame overlaps the start of the next.
  rbc_cmd_t cmd;
  logic     frame_red;

  rbc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_pix.valid),
    .in_frame_end (in_pix.frame_end),
    .frame_red    (frame_red),
    .out_ready    (out_res.ready),
    .in_ready     (in_pix.ready),
    .out_valid    (out_res.valid),
    .cmd          (cmd)
  );

  // The datapath keeps the redness and area thresholds; the controller
  // keeps the confidence limit. Both decode the same write port.
  rbc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .blue          (in_pix.blue),
    .green         (in_pix.green),
    .red           (in_pix.red),
    .column        (in_pix.column),
    .row_index     (in_pix.row_index),
    .frame_red     (frame_red),
    .stop_detected (out_res.stop_detected),
    .centroid_x    (out_res.centroid_x),
    .centroid_y    (out_res.centroid_y)
  );

  // Only a frame-end pixel is ever refused.
  a_ready_only_frame_end : assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> in_pix.frame_end)
    else $error("pixel refused that does not end a frame");

  // A new frame verdict is never taken while a result is still offered.
  a_no_close_while_pending : assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready && in_pix.frame_end) |-> !out_res.valid)
    else $error("frame closed while a result was pending");

  // Each frame gives at most one result, so a taken result is not offered again.
  a_single_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.ready) |=> !out_res.valid)
    else $error("result offered twice");

  // A clear result carries zero coordinates.
  a_clear_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.stop_detected) |->
      (out_res.centroid_x == '0 && out_res.centroid_y == '0))
    else $error("clear result with a non-zero centroid");

endmodule

`default_nettype wire
